[rtl/core/bms_pkg.sv]
package bms_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 512;
  localparam int LINE_DEPTH   = 3 * FRAME_WIDTH;

  localparam int COL_W  = $clog2(FRAME_WIDTH);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT);
  localparam int ADDR_W = $clog2(LINE_DEPTH);

  // Field widths fixed by the stream format
  localparam int HGT_W   = 9;
  localparam int LIGHT_W = 9;
  localparam int PIX_W   = 9;
  localparam int COLOR_W = 16;

  // Width of the signed light differences
  localparam int CRD_W = (COL_W > ROW_W) ? ((COL_W > HGT_W) ? COL_W : HGT_W)
                                         : ((ROW_W > HGT_W) ? ROW_W : HGT_W);
  localparam int DIFF_W = CRD_W + 2;

  // Shade saturation
  localparam int SHADE_W   = 8;
  localparam int SHADE_MAX = 255;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIGHT_W;
  localparam logic [LIGHT_W-1:0] LIGHT_RESET = LIGHT_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X = 1'b0,
    REG_LIGHT_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [HGT_W-1:0] height;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [PIX_W-1:0]   pixel_column;
    logic [PIX_W-1:0]   pixel_row;
    logic               frame_last;
  } out_t;

  // Classified item handed from the front end to the shader
  typedef struct packed {
    logic             valid;
    logic [HGT_W-1:0] h0;
    logic [HGT_W-1:0] hx;
    logic [HGT_W-1:0] hy;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] prow;
    logic             last;
  } job_t;

endpackage

[rtl/core/bms_ram.sv]
module bms_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the address being written returns the old data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[rtl/core/bms_front.sv]
module bms_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  bms_pkg::in_t in_item,
  output logic         emit,
  output bms_pkg::job_t job
);
  import bms_pkg::*;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] base;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [ADDR_W-1:0] base_next;

  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [ADDR_W-1:0] base_cur;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W:0]   slot3_raw;
  logic [ADDR_W-1:0] slot3;

  logic              s1_valid;
  logic [HGT_W-1:0]  s1_hy;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_prow;
  logic              s1_last;
  logic [HGT_W-1:0]  rd_h0;
  logic [HGT_W-1:0]  rd_hx;

  // Raster position of this sample; frame_start restarts at the origin
  always_comb begin
    col_cur  = in_item.frame_start ? '0 : col;
    row_cur  = in_item.frame_start ? '0 : row;
    base_cur = in_item.frame_start ? '0 : base;
    slot     = base_cur + ADDR_W'(col_cur);
    // sample three positions on, wrapping round the three-row line
    slot3_raw = {1'b0, slot} + (ADDR_W+1)'(3);
    if (slot3_raw >= (ADDR_W+1)'(LINE_DEPTH)) begin
      slot3 = ADDR_W'(slot3_raw - (ADDR_W+1)'(LINE_DEPTH));
    end else begin
      slot3 = slot3_raw[ADDR_W-1:0];
    end
    emit = row_cur >= ROW_W'(3);
  end

  // Next position, base tracks (row mod 3) * width
  always_comb begin
    col_next  = col_cur + COL_W'(1);
    row_next  = row_cur;
    base_next = base_cur;
    if (col_cur == COL_W'(FRAME_WIDTH - 1)) begin
      col_next = '0;
      if (row_cur == ROW_W'(FRAME_HEIGHT - 1)) begin
        row_next  = '0;
        base_next = '0;
      end else begin
        row_next = row_cur + ROW_W'(1);
        if (base_cur == ADDR_W'(2 * FRAME_WIDTH)) begin
          base_next = '0;
        end else begin
          base_next = base_cur + ADDR_W'(FRAME_WIDTH);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      base     <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && emit;
      if (accept) begin
        col  <= col_next;
        row  <= row_next;
        base <= base_next;
      end
    end
  end

  // Item details, aligned with the delay-line read data
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hy   <= in_item.height;
      s1_col  <= col_cur;
      s1_prow <= row_cur - ROW_W'(3);
      s1_last <= row_cur == ROW_W'(FRAME_HEIGHT - 1)
              && col_cur == COL_W'(FRAME_WIDTH - 1);
    end
  end

  // Two copies of the delay line give the two reads per sample
  bms_ram #(.WIDTH(HGT_W), .DEPTH(LINE_DEPTH)) u_line_own (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (slot),
    .wr_data (in_item.height),
    .rd_addr (slot),
    .rd_data (rd_h0)
  );

  bms_ram #(.WIDTH(HGT_W), .DEPTH(LINE_DEPTH)) u_line_next (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (slot),
    .wr_data (in_item.height),
    .rd_addr (slot3),
    .rd_data (rd_hx)
  );

  always_comb begin
    job.valid = s1_valid;
    job.h0    = rd_h0;
    job.hx    = rd_hx;
    job.hy    = s1_hy;
    job.col   = s1_col;
    job.prow  = s1_prow;
    job.last  = s1_last;
  end

endmodule

[rtl/core/bms_shade.sv]
module bms_shade (
  input  logic                        clk,
  input  logic                        rst,
  input  bms_pkg::job_t               job,
  input  logic [bms_pkg::LIGHT_W-1:0] light_x,
  input  logic [bms_pkg::LIGHT_W-1:0] light_y,
  output logic                        res_valid,
  output bms_pkg::out_t               res
);
  import bms_pkg::*;

  logic [DIFF_W-1:0]  dx;
  logic [DIFF_W-1:0]  dy;
  logic [DIFF_W-1:0]  a_dx;
  logic [DIFF_W-1:0]  a_dy;
  logic               a_valid;
  logic [COL_W-1:0]   a_col;
  logic [ROW_W-1:0]   a_prow;
  logic               a_last;
  logic [DIFF_W:0]    sum;
  logic [SHADE_W-1:0] sat;
  logic [SHADE_W-1:0] shade;

  // Signed offsets in two's complement; range fits DIFF_W
  always_comb begin
    dx = DIFF_W'(job.h0) + DIFF_W'(job.col) - DIFF_W'(job.hx) - DIFF_W'(light_x);
    dy = DIFF_W'(job.h0) + DIFF_W'(job.prow) - DIFF_W'(job.hy) - DIFF_W'(light_y);
  end

  // Stage A: absolute values
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= job.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_dx   <= dx[DIFF_W-1] ? -dx : dx;
    a_dy   <= dy[DIFF_W-1] ? -dy : dy;
    a_col  <= job.col;
    a_prow <= job.prow;
    a_last <= job.last;
  end

  // Stage B: sum, saturate, invert and pack as RGB565
  always_comb begin
    sum = (DIFF_W+1)'(a_dx) + (DIFF_W+1)'(a_dy);
    if (sum > (DIFF_W+1)'(SHADE_MAX)) begin
      sat = SHADE_W'(SHADE_MAX);
    end else begin
      sat = sum[SHADE_W-1:0];
    end
    shade = ~sat;
    res_valid        = a_valid;
    res.pixel_color  = {1'b0, shade[7:4], 1'b0, shade[7:3], shade[7:3]};
    res.pixel_column = PIX_W'(a_col);
    res.pixel_row    = PIX_W'(a_prow);
    res.frame_last   = a_last;
  end

endmodule

[rtl/core/bms_fifo.sv]
module bms_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bms_pkg::out_t push_data,
  input  logic          pop,
  output bms_pkg::out_t data,
  output logic          empty
);
  import bms_pkg::*;

  out_t                  entry [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign data  = entry[rd_ptr];
  assign empty = count == '0;

endmodule

[rtl/core/bump_map_shader_stream_core.sv]
// Channel  Ports                                    Transfer when
// input    push, full, in_item (height,frame_start) push && !full
// result   empty, pop, out_item (colour, position)  pop && !empty
// config   cfg_write, cfg_index, cfg_data           cfg_write
//
// One sample per cycle is taken in while full is low. A pixel reaches the result ports through
// the delay-line read, then the difference stage, then shade into the queue.
// full rises only while the eight-entry result queue, counting pixels still
// in flight, has no free slot; a stalled pop then holds the input back.
// Synchronous reset clears the raster position and the queue, and sets both lights to 256.
// The delay line is not cleared: each frame refills three rows before use.
module bump_map_shader_stream_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  bms_pkg::in_t                  in_item,
  output logic                          empty,
  input  logic                          pop,
  output bms_pkg::out_t                 out_item,
  input  logic                          cfg_write,
  input  logic [bms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bms_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bms_pkg::*;

  logic                  accept;
  logic                  emit;
  logic                  take;
  job_t                  job;
  logic                  res_valid;
  out_t                  res;
  logic [LIGHT_W-1:0]    light_x;
  logic [LIGHT_W-1:0]    light_y;
  logic [FIFO_CNT_W-1:0] credit;

  assign accept = push && !full;
  assign take   = pop && !empty;

  // Light registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= LIGHT_RESET;
      light_y <= LIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LIGHT_X: light_x <= LIGHT_W'(cfg_data);
        REG_LIGHT_Y: light_y <= LIGHT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Queue slots reserved by pixels in flight or waiting
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if ((accept && emit) && !take) begin
      credit <= credit + FIFO_CNT_W'(1);
    end else if (take && !(accept && emit)) begin
      credit <= credit - FIFO_CNT_W'(1);
    end
  end

  assign full = credit == FIFO_CNT_W'(FIFO_DEPTH);

  bms_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_item (in_item),
    .emit    (emit),
    .job     (job)
  );

  bms_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .light_x   (light_x),
    .light_y   (light_y),
    .res_valid (res_valid),
    .res       (res)
  );

  bms_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (take),
    .data      (out_item),
    .empty     (empty)
  );

endmodule

[tb/bump_map_shader_stream_core_tb.sv]
`timescale 1ns / 1ps
module bump_map_shader_stream_core_tb;
  import bms_pkg::*;

  localparam int CYCLE_LIMIT  = 100_000;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  full;
  in_t                   in_item   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_t                  out_item;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_LIGHT_X;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Handshake pressure, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int     mismatch_count   = 0;
  longint cycle_count      = 0;

  // Shadow copy of the block: three rows of heights, raster position, lights
  logic [HGT_W-1:0]   height_rows [LINE_DEPTH];
  int                 next_col    = 0;
  int                 next_row    = 0;
  logic [LIGHT_W-1:0] light_x_q   = LIGHT_RESET;
  logic [LIGHT_W-1:0] light_y_q   = LIGHT_RESET;
  out_t               pending_pixels [$];

  bump_map_shader_stream_core dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Shade one sample and queue the pixel it completes, if any
  function automatic void predict_pixel(input logic [HGT_W-1:0] h, input logic fs);
    int   slot;
    int   h0;
    int   hx;
    int   prow;
    int   dx;
    int   dy;
    int   s;
    int   c;
    out_t px;
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    slot = (next_row % 3) * FRAME_WIDTH + next_col;
    if (next_row >= 3) begin
      // slot still holds the sample three rows up; hx may sit in the next row
      h0   = int'(height_rows[ADDR_W'(slot)]);
      hx   = int'(height_rows[ADDR_W'((slot + 3) % LINE_DEPTH)]);
      prow = next_row - 3;
      dx   = h0 + next_col - hx - int'(light_x_q);
      dy   = h0 + prow - int'(h) - int'(light_y_q);
      s    = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
      if (s > SHADE_MAX) s = SHADE_MAX;
      c = SHADE_MAX - s;
      px.pixel_color  = COLOR_W'(((c >> 4) << 11) | ((c >> 3) << 5) | (c >> 3));
      px.pixel_column = PIX_W'(next_col);
      px.pixel_row    = PIX_W'(prow);
      px.frame_last   = (prow == FRAME_HEIGHT - 4) && (next_col == FRAME_WIDTH - 1);
      pending_pixels.push_back(px);
    end
    height_rows[ADDR_W'(slot)] = h;
    if (next_col + 1 >= FRAME_WIDTH) begin
      next_col = 0;
      next_row = (next_row + 1 >= FRAME_HEIGHT) ? 0 : next_row + 1;
    end else begin
      next_col = next_col + 1;
    end
  endfunction

  function automatic logic [HGT_W-1:0] random_height();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return HGT_W'($urandom_range(0, (1 << HGT_W) - 1));
  endfunction

  task automatic report_error(input string what, input out_t want, input out_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected colour %h col %0d row %0d last %0b",
               what, want.pixel_color, want.pixel_column, want.pixel_row, want.frame_last);
      $display("  got colour %h col %0d row %0d last %0b",
               got.pixel_color, got.pixel_column, got.pixel_row, got.frame_last);
    end
  endtask

  // Result side: check each transfer, then pick next cycle's pop
  always @(posedge clk) begin : check_pixels
    out_t want;
    if (!rst && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        report_error("unexpected pixel", '0, out_item);
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.pixel_color !== want.pixel_color ||
            out_item.pixel_column !== want.pixel_column ||
            out_item.pixel_row !== want.pixel_row ||
            out_item.frame_last !== want.frame_last)
          report_error("pixel mismatch", want, out_item);
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // One input transfer; push stays high for a following item
  task automatic send_sample(input logic [HGT_W-1:0] h, input logic fs);
    in_t item;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item.height      = h;
    item.frame_start = fs;
    push    <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (full);
    predict_pixel(h, fs);
  endtask

  // Hold the input until all pixels are out and the pipe has settled
  task automatic drain_pixels();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_lights(input logic [LIGHT_W-1:0] lx, input logic [LIGHT_W-1:0] ly);
    cfg_write <= 1'b1;
    cfg_index <= REG_LIGHT_X;
    cfg_data  <= lx;
    @(posedge clk);
    cfg_index <= REG_LIGHT_Y;
    cfg_data  <= ly;
    @(posedge clk);
    cfg_write <= 1'b0;
    light_x_q = lx;
    light_y_q = ly;
  endtask

  // Flat field so that shade runs from near zero to saturation
  task automatic test_light_extremes();
    int               i;
    logic [HGT_W-1:0] hy_set [4];
    hy_set = '{9'd100, 9'd0, 9'd511, 9'd256};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_pixels();
    set_lights('0, '0);
    // first three rows only fill the delay line
    for (i = 0; i < LINE_DEPTH; i++)
      send_sample((i % FRAME_WIDTH < 32) ? 9'd100 : random_height(), i == 0);
    for (i = 0; i < 12; i++) send_sample(hy_set[2'(i % 4)], 1'b0);
    // sender holds off until every pixel has been checked
    drain_pixels();
    set_lights('1, '1);
    for (i = 0; i < 12; i++) send_sample(hy_set[2'(i % 4)], 1'b0);
  endtask

  // Frame start mid-frame, once past the fill and once during the refill
  task automatic test_mid_frame_restart();
    int i;
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    for (i = 0; i < 40; i++) send_sample(random_height(), 1'b0);
    for (i = 0; i < 48; i++) send_sample(random_height(), i == 0);
    for (i = 0; i < 48; i++) send_sample(random_height(), i == 0);
  endtask

  // Random stream under each pressure pattern
  task automatic test_random_stream();
    int               ph;
    int               items;
    int               idle_set  [4];
    int               stall_set [4];
    logic [LIGHT_W-1:0] lx;
    logic [LIGHT_W-1:0] ly;
    idle_set  = '{0, 84, 0, 21};
    stall_set = '{0, 0, 84, 21};
    for (ph = 0; ph < 4; ph++) begin
      drain_pixels();
      lx = LIGHT_W'($urandom_range(0, 511));
      ly = LIGHT_W'($urandom_range(0, 511));
      if (ph == 1) begin
        lx = '0;
        ly = '1;
      end else if (ph == 2) begin
        lx = '1;
        ly = '0;
      end
      set_lights(lx, ly);
      send_idle_pct  = idle_set[2'(ph)];
      recv_stall_pct = stall_set[2'(ph)];
      for (items = 0; items < 40; items++) begin
        send_sample(random_height(), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_light_extremes();
    test_random_stream();
    test_mid_frame_restart();
    drain_pixels();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
